// File: hw/rtl/assert_macros.svh
// Assertion helpers included by the top-level RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SOIE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SOIE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/soie_pkg.sv
package soie_pkg;

    localparam int DATA_WIDTH_DEF = 64;
    localparam int MAX_RUN_DEF    = 64;
    localparam int VALUE_W        = 64;
    localparam int RESULT_W       = 63;
    localparam int MODE_W         = 2;
    localparam int KIND_W         = 2;
    localparam int ERR_W          = 3;

    // Mode register codes
    localparam logic [MODE_W-1:0] MODE_LEN_TO_OFF = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LEN_TO_IDX = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OFF_TO_IDX = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESERVED   = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_OFFSET = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INDEX  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
    localparam logic [ERR_W-1:0] ERR_NEG_LENGTH = 3'd1;
    localparam logic [ERR_W-1:0] ERR_DEC_OFFSET = 3'd2;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_RUN_LONG   = 3'd4;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      start_req;
    } soie_in_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [RESULT_W-1:0] result_value;
        logic [RESULT_W-1:0] position;
        logic [ERR_W-1:0]    error_code;
        logic                last_of_run;
    } soie_out_t;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic emit_total;
        logic emit_elem;
    } soie_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic go_total;
        logic go_run;
        logic run_last;
    } soie_status_t;

endpackage

// File: hw/rtl/segment_offsets_and_index_expand.sv
// Channel   | Ports                            | Transfer
// ----------+----------------------------------+------------------------------------
// input     | s_valid, s_ready, s_data         | one length or offset, start marker
// result    | m_valid, m_ready, m_data         | one offset, segment number or error
// config    | cfg_valid, cfg_ready, cfg_data   | mode register write
//
// An item yields at most one result; a start in lengths-to-offsets mode yields
// a leading zero and then the total; an index run of length L yields L results,
// one result per cycle through the single output register unless output stalls.
// Input stalls while a run or the trailing total is still being emitted.
// Reset is synchronous, active low, and clears the mode and sequence state.
// Output stalls hold the result register and back-pressure the input.
module segment_offsets_and_index_expand import soie_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int MAX_RUN    = MAX_RUN_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  soie_in_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output soie_out_t         m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [MODE_W-1:0] cfg_data
);

`include "assert_macros.svh"

    soie_cmd_t    cmd;
    soie_status_t status;
    logic         cfg_write;

    // Mode writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    soie_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    soie_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .MAX_RUN    (MAX_RUN)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_write),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    `SOIE_ASSERT_IMP(a_emit_needs_room, aclk, aresetn, cmd.emit_total || cmd.emit_elem, status.out_free, "result emitted into a full output register")
    `SOIE_ASSERT_IMP(a_take_excludes_emit, aclk, aresetn, cmd.take, !(cmd.emit_total || cmd.emit_elem), "item taken while results still pending")
    `SOIE_ASSERT_IMP(a_error_is_last, aclk, aresetn, m_valid && (m_data.kind == KIND_ERROR), m_data.last_of_run && (m_data.result_value == '0), "error result not marked last")
    `SOIE_ASSERT_NXT(a_run_blocks_input, aclk, aresetn, status.go_run, !s_ready, "input accepted during a run")

endmodule

// File: hw/rtl/soie_dp.sv
module soie_dp import soie_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int MAX_RUN    = MAX_RUN_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  soie_in_t           s_data,
    input  logic               cfg_valid,
    input  logic [MODE_W-1:0]  cfg_data,
    input  soie_cmd_t          cmd,
    output soie_status_t       status,
    output logic               m_valid,
    input  logic               m_ready,
    output soie_out_t          m_data
);

    localparam int RUN_W = $clog2(MAX_RUN + 1);
    localparam logic [VALUE_W-1:0] TOTAL_LIMIT = {VALUE_W{1'b1}} >> (65 - DATA_WIDTH);
    localparam logic [VALUE_W-1:0] RUN_LIMIT   = VALUE_W'(MAX_RUN);

    logic [MODE_W-1:0]   mode_reg;
    logic                active_reg;
    logic                failed_reg;
    logic [VALUE_W-1:0]  total_reg;
    logic [VALUE_W-1:0]  prev_reg;
    logic [VALUE_W-1:0]  base_reg;
    logic [VALUE_W-1:0]  seg_reg;
    logic [RESULT_W-1:0] run_seg_reg;
    logic [RESULT_W-1:0] run_pos_reg;
    logic [RUN_W-1:0]    run_left_reg;
    logic                m_valid_reg;
    soie_out_t           m_data_reg;
    soie_out_t           m_data_next;

    logic [VALUE_W-1:0]  value_ext;
    logic                start;
    logic                drop;
    logic                silent_start;
    logic [VALUE_W-1:0]  total_eff;
    logic [VALUE_W-1:0]  seg_eff;
    logic [VALUE_W-1:0]  room;
    logic [VALUE_W-1:0]  total_sum;
    logic [VALUE_W-1:0]  step;
    logic [VALUE_W-1:0]  span;
    logic [VALUE_W-1:0]  first_full;
    logic [VALUE_W-1:0]  len_full;
    logic [RUN_W-1:0]    run_len;
    logic [RESULT_W-1:0] run_first;
    logic [ERR_W-1:0]    err;
    logic                is_run;
    logic                load_first;
    logic                load;
    logic                out_free;
    logic                accept;

    // Decode the offered item against the current sequence state
    always_comb begin
        value_ext    = VALUE_W'($signed(s_data.value[DATA_WIDTH-1:0]));
        start        = s_data.start_req;
        drop         = (mode_reg == MODE_RESERVED) || (!start && (!active_reg || failed_reg));
        silent_start = start && (mode_reg == MODE_OFF_TO_IDX);
        total_eff    = start ? '0 : total_reg;
        seg_eff      = start ? '0 : seg_reg;
        room         = TOTAL_LIMIT - total_eff;
        total_sum    = total_eff + value_ext;
        step         = value_ext - prev_reg;
        span         = value_ext - base_reg;

        err = ERR_NONE;
        if (mode_reg != MODE_OFF_TO_IDX) begin
            if (value_ext[VALUE_W-1]) begin
                err = ERR_NEG_LENGTH;
            end else if (value_ext > room) begin
                err = ERR_OVERFLOW;
            end else if ((mode_reg == MODE_LEN_TO_IDX) && (value_ext > RUN_LIMIT)) begin
                err = ERR_RUN_LONG;
            end
        end else if (!silent_start) begin
            if ($signed(value_ext) < $signed(prev_reg)) begin
                err = ERR_DEC_OFFSET;
            end else if (span > TOTAL_LIMIT) begin
                err = ERR_OVERFLOW;
            end else if (step > RUN_LIMIT) begin
                err = ERR_RUN_LONG;
            end
        end

        if (mode_reg == MODE_LEN_TO_IDX) begin
            len_full   = value_ext;
            first_full = total_eff;
        end else begin
            len_full   = step;
            first_full = prev_reg - base_reg;
        end
        run_len   = len_full[RUN_W-1:0];
        run_first = first_full[RESULT_W-1:0];

        is_run = !drop && !silent_start && (err == ERR_NONE)
                 && (mode_reg != MODE_LEN_TO_OFF);
    end

    // Pick the result to load into the output register
    always_comb begin
        load_first = cmd.take && !drop && !silent_start && !(is_run && (run_len == '0));
        load       = load_first || cmd.emit_total || cmd.emit_elem;

        m_data_next              = m_data_reg;
        m_data_next.kind         = KIND_OFFSET;
        m_data_next.result_value = '0;
        m_data_next.position     = '0;
        m_data_next.error_code   = ERR_NONE;
        m_data_next.last_of_run  = 1'b1;
        if (cmd.emit_total) begin
            m_data_next.result_value = total_reg[RESULT_W-1:0];
        end else if (cmd.emit_elem) begin
            m_data_next.kind         = KIND_INDEX;
            m_data_next.result_value = run_seg_reg;
            m_data_next.position     = run_pos_reg;
            m_data_next.last_of_run  = (run_left_reg == RUN_W'(1));
        end else if (err != ERR_NONE) begin
            m_data_next.kind       = KIND_ERROR;
            m_data_next.error_code = err;
        end else if (mode_reg == MODE_LEN_TO_OFF) begin
            // Leading zero comes first on a start; the total follows
            if (start) begin
                m_data_next.last_of_run = 1'b0;
            end else begin
                m_data_next.result_value = total_sum[RESULT_W-1:0];
            end
        end else begin
            m_data_next.kind         = KIND_INDEX;
            m_data_next.result_value = seg_eff[RESULT_W-1:0];
            m_data_next.position     = run_first;
            m_data_next.last_of_run  = (run_len == RUN_W'(1));
        end
    end

    assign accept          = cmd.take && !drop;
    assign out_free        = !m_valid_reg || m_ready;
    assign status.out_free = out_free;
    assign status.go_total = cmd.take && !drop && start && (mode_reg == MODE_LEN_TO_OFF)
                             && (err == ERR_NONE);
    assign status.go_run   = cmd.take && is_run && (run_len > RUN_W'(1));
    assign status.run_last = (run_left_reg == RUN_W'(1));

    // Sequence state, mode and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_LEN_TO_OFF;
            active_reg  <= 1'b0;
            failed_reg  <= 1'b0;
            total_reg   <= '0;
            prev_reg    <= '0;
            base_reg    <= '0;
            seg_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                mode_reg <= cfg_data;
            end
            // A start opens the sequence; a mode write closes it
            if (accept && start) begin
                active_reg <= 1'b1;
            end else if (cfg_valid) begin
                active_reg <= 1'b0;
            end
            if (accept) begin
                if (err != ERR_NONE) begin
                    failed_reg <= 1'b1;
                end else if (start) begin
                    failed_reg <= 1'b0;
                end
                if ((err == ERR_NONE) && (mode_reg != MODE_OFF_TO_IDX)) begin
                    total_reg <= total_sum;
                end else if (start) begin
                    total_reg <= '0;
                end
                if (is_run) begin
                    seg_reg <= seg_eff + VALUE_W'(1);
                end else if (start) begin
                    seg_reg <= '0;
                end
                if (silent_start || (is_run && (mode_reg == MODE_OFF_TO_IDX))) begin
                    prev_reg <= value_ext;
                end else if (start) begin
                    prev_reg <= '0;
                end
                if (silent_start) begin
                    base_reg <= value_ext;
                end else if (start) begin
                    base_reg <= '0;
                end
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Run counters and output payload
    always_ff @(posedge aclk) begin
        if (cmd.take && is_run) begin
            run_seg_reg  <= seg_eff[RESULT_W-1:0];
            run_pos_reg  <= run_first + RESULT_W'(1);
            run_left_reg <= run_len - RUN_W'(1);
        end else if (cmd.emit_elem) begin
            run_pos_reg  <= run_pos_reg + RESULT_W'(1);
            run_left_reg <= run_left_reg - RUN_W'(1);
        end
        if (load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: hw/rtl/soie_ctrl.sv
module soie_ctrl import soie_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  soie_status_t status,
    output soie_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_TOTAL = 2'd1;
    localparam logic [1:0] S_RUN   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Take items only when idle and the output register can be refilled
    assign s_ready = (state_reg == S_IDLE) && status.out_free;

    always_comb begin
        state_next     = state_reg;
        cmd.take       = 1'b0;
        cmd.emit_total = 1'b0;
        cmd.emit_elem  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                cmd.take = s_valid && status.out_free;
                if (status.go_total) begin
                    state_next = S_TOTAL;
                end else if (status.go_run) begin
                    state_next = S_RUN;
                end
            end
            S_TOTAL: begin
                if (status.out_free) begin
                    cmd.emit_total = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RUN: begin
                if (status.out_free) begin
                    cmd.emit_elem = 1'b1;
                    if (status.run_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
